[hw/rtl/misaligned_load_store_unit_macros.svh]
// ---------------------------------------------------------------------------
// misaligned load/store unit assertion macros
// shared concurrent assertion forms, clocked and disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef MISALIGNED_LOAD_STORE_UNIT_MACROS_SVH
`define MISALIGNED_LOAD_STORE_UNIT_MACROS_SVH

// same-cycle implication
`define MLSU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mlsu assertion failed");

// next-cycle implication
`define MLSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mlsu assertion failed");

`endif

[hw/rtl/mlsu_pkg.sv]
// ---------------------------------------------------------------------------
// mlsu_pkg
// shared types, codes and lane helpers of the misaligned load/store unit
// ---------------------------------------------------------------------------
`default_nettype none

package mlsu_pkg;

  typedef logic [63:0] word_t;
  typedef logic [3:0]  count_t;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_STORE = 1'b1;

  localparam count_t MAX_BYTES = 4'd8;

  localparam word_t SX_MASK_4 = 64'hFFFF_FFFF_0000_0000;
  localparam word_t SX_MASK_2 = 64'hFFFF_FFFF_FFFF_0000;
  localparam word_t SX_MASK_1 = 64'hFFFF_FFFF_FFFF_FF00;

  typedef struct packed {
    word_t load_data;
    logic  out_of_range;
  } res_t;

  // one bit per byte to one byte per bit
  function automatic logic [127:0] expand_mask(input logic [15:0] bm);
    logic [127:0] m;
    m = '0;
    for (int i = 0; i < 16; i++) begin
      m[i*8 +: 8] = {8{bm[i]}};
    end
    return m;
  endfunction

  function automatic logic [7:0] byte_mask(input count_t cnt);
    logic [8:0] m;
    m = (9'd1 << cnt) - 9'd1;
    return m[7:0];
  endfunction

  // zero or sign extension of a loaded value
  function automatic word_t widen(input word_t v, input count_t cnt, input logic sx);
    word_t r;
    r = v;
    if (sx) begin
      if (cnt == 4'd4 && v[31]) begin
        r = v | SX_MASK_4;
      end else if (cnt == 4'd2 && v[15]) begin
        r = v | SX_MASK_2;
      end else if (cnt == 4'd1 && v[7]) begin
        r = v | SX_MASK_1;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/mlsu_in_if.sv]
// ---------------------------------------------------------------------------
// mlsu_in_if
// request channel: one load or store access per word
// ---------------------------------------------------------------------------
`default_nettype none

interface mlsu_in_if;
  logic             valid;
  logic             ready;
  logic             func;
  mlsu_pkg::word_t  address;
  mlsu_pkg::count_t byte_count;
  logic             sign_extend;
  mlsu_pkg::word_t  store_data;

  modport source (output valid, func, address, byte_count, sign_extend, store_data,
                  input ready);
  modport sink (input valid, func, address, byte_count, sign_extend, store_data,
                output ready);
endinterface

`default_nettype wire

[hw/rtl/mlsu_out_if.sv]
// ---------------------------------------------------------------------------
// mlsu_out_if
// result channel: loaded value and range flag, one per request
// ---------------------------------------------------------------------------
`default_nettype none

interface mlsu_out_if;
  logic            valid;
  logic            ready;
  mlsu_pkg::word_t load_data;
  logic            out_of_range;

  modport source (output valid, load_data, out_of_range, input ready);
  modport sink (input valid, load_data, out_of_range, output ready);
endinterface

`default_nettype wire

[hw/rtl/mlsu_mem.sv]
// ---------------------------------------------------------------------------
// mlsu_mem
// word memory, one write port and one registered read port
// ---------------------------------------------------------------------------
`default_nettype none

module mlsu_mem #(
  parameter int DEPTH_WORDS = 1024,
  parameter int AW          = 10
) (
  input  wire logic            clk,
  input  wire logic            we,
  input  wire logic [AW-1:0]   waddr,
  input  wire mlsu_pkg::word_t wdata,
  input  wire logic            re,
  input  wire logic [AW-1:0]   raddr,
  output mlsu_pkg::word_t      rdata
);
  import mlsu_pkg::*;

  word_t mem [DEPTH_WORDS];
  word_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[hw/rtl/mlsu_core.sv]
// ---------------------------------------------------------------------------
// mlsu_core
// access sequencer: range check, word reads, byte merge and write back
// ---------------------------------------------------------------------------
`default_nettype none

`include "misaligned_load_store_unit_macros.svh"

module mlsu_core #(
  parameter int DEPTH_WORDS = 1024
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire mlsu_pkg::word_t base_addr,
  mlsu_in_if.sink              in_chan,
  output logic                 res_valid,
  input  wire logic            res_ready,
  output mlsu_pkg::res_t       res
);
  import mlsu_pkg::*;

  localparam int AW = (DEPTH_WORDS > 1) ? $clog2(DEPTH_WORDS) : 1;
  localparam word_t BANK_BYTES = 64'(DEPTH_WORDS) * 64'd8;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_RD0   = 3'd2;
  localparam logic [2:0] ST_RD1   = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       func_r;
  word_t      rel_r;
  count_t     cnt_r;
  logic       sx_r;
  word_t      sdata_r;
  word_t      lo_r, lo_nxt;
  res_t       res_r, res_nxt;

  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr;
  word_t         mem_wdata, mem_rdata;

  logic [2:0]    off;
  logic [AW-1:0] w0, w1;
  logic          spans, oor;
  logic [15:0]   bm16;
  logic [127:0]  bmask, sdata_sh, ld_sh, ld_mask;
  logic [6:0]    shamt;
  count_t        cnt_in;
  word_t         ld_hi;

  mlsu_mem #(
    .DEPTH_WORDS (DEPTH_WORDS),
    .AW          (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_chan.ready = (state_r == ST_IDLE);
  assign cnt_in = (in_chan.byte_count > MAX_BYTES) ? MAX_BYTES : in_chan.byte_count;

  assign off      = rel_r[2:0];
  assign w0       = rel_r[AW+2:3];
  assign w1       = w0 + 1'b1;
  assign spans    = ({1'b0, off} + cnt_r) > MAX_BYTES;
  assign oor      = rel_r > (BANK_BYTES - {60'd0, cnt_r});
  assign shamt    = {1'b0, off, 3'b000};
  assign bm16     = {8'd0, byte_mask(cnt_r)} << off;
  assign bmask    = expand_mask(bm16);
  assign ld_mask  = expand_mask({8'd0, byte_mask(cnt_r)});
  assign sdata_sh = {64'd0, sdata_r} << shamt;
  assign ld_hi    = (state_r == ST_RD1) ? mem_rdata : 64'd0;
  assign ld_sh    = {ld_hi, (state_r == ST_RD1) ? lo_r : mem_rdata} >> shamt;

  always_comb begin
    state_nxt = state_r;
    lo_nxt    = lo_r;
    res_nxt   = res_r;
    mem_we    = 1'b0;
    mem_waddr = w0;
    mem_wdata = (mem_rdata & ~bmask[63:0]) | (sdata_sh[63:0] & bmask[63:0]);
    mem_re    = 1'b0;
    mem_raddr = w0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        res_nxt = '{load_data: '0, out_of_range: 1'b0};
        if (cnt_r == 4'd0) begin
          state_nxt = ST_DONE;
        end else if (oor) begin
          res_nxt.out_of_range = 1'b1;
          state_nxt            = ST_DONE;
        end else begin
          mem_re    = 1'b1;
          state_nxt = ST_RD0;
        end
      end
      ST_RD0: begin
        lo_nxt = mem_rdata;
        mem_we = (func_r == FUNC_STORE);
        if (spans) begin
          mem_re    = 1'b1;
          mem_raddr = w1;
          state_nxt = ST_RD1;
        end else begin
          if (func_r == FUNC_LOAD) begin
            res_nxt.load_data = widen(ld_sh[63:0] & ld_mask[63:0], cnt_r, sx_r);
          end
          state_nxt = ST_DONE;
        end
      end
      ST_RD1: begin
        mem_we    = (func_r == FUNC_STORE);
        mem_waddr = w1;
        mem_wdata = (mem_rdata & ~bmask[127:64]) | (sdata_sh[127:64] & bmask[127:64]);
        if (func_r == FUNC_LOAD) begin
          res_nxt.load_data = widen(ld_sh[63:0] & ld_mask[63:0], cnt_r, sx_r);
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_chan.valid) begin
      func_r  <= in_chan.func;
      rel_r   <= in_chan.address - base_addr;
      cnt_r   <= cnt_in;
      sx_r    <= in_chan.sign_extend;
      sdata_r <= in_chan.store_data;
    end
    lo_r  <= lo_nxt;
    res_r <= res_nxt;
  end

  assign res_valid = (state_r == ST_DONE);
  assign res       = res_r;

  `MLSU_ASSERT_NOW(a_we_store_only, clk, rst_n, mem_we,
    func_r == FUNC_STORE && (state_r == ST_RD0 || state_r == ST_RD1))
  `MLSU_ASSERT_NOW(a_oor_zero, clk, rst_n, res_valid && res.out_of_range,
    res.load_data == 64'd0)
  `MLSU_ASSERT_NEXT(a_span_second, clk, rst_n, state_r == ST_RD0 && spans,
    state_r == ST_RD1)
  `MLSU_ASSERT_NOW(a_read_in_bank, clk, rst_n, mem_re, !oor && cnt_r != 4'd0)

endmodule

`default_nettype wire

[hw/rtl/misaligned_load_store_unit.sv]
// ---------------------------------------------------------------------------
// misaligned_load_store_unit
// byte-addressed loads and stores over a bank of DEPTH_WORDS 64-bit words
// in_chan carries one access per word: func (load or store), absolute byte
// address, byte_count 1..8 (larger counts act as 8), sign_extend for loads
// of 1, 2 or 4 bytes, and store_data; out_chan returns one word per access:
// load_data (zero for stores) and out_of_range, set when any byte falls
// outside the bank, in which case memory is left untouched
// cfg_wr_en / cfg_wr_data write base_address; the user must do so only while
// nothing is in flight: the block does not enforce it. An access runs a range
// check, a read of its first word and, across a word boundary, of the second,
// then a final step; rejected or empty ones skip the reads. A store merges and
// writes back each word as its data returns. A new access is taken only in
// idle, after the last is through. The result sits in an output register, so
// a new access is accepted while the previous result waits; a stalled receiver
// holds the sequencer in its final step until the register frees
// synchronous reset clears control state and base_address only
// ---------------------------------------------------------------------------
`default_nettype none

module misaligned_load_store_unit #(
  parameter int DEPTH_WORDS = 1024
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            cfg_wr_en,
  input  wire mlsu_pkg::word_t cfg_wr_data,
  mlsu_in_if.sink              in_chan,
  mlsu_out_if.source           out_chan
);
  import mlsu_pkg::*;

  word_t base_r;
  logic  res_valid, res_ready;
  res_t  res;
  logic  out_valid_r;
  res_t  out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else if (cfg_wr_en) begin
      base_r <= cfg_wr_data;
    end
  end

  mlsu_core #(
    .DEPTH_WORDS (DEPTH_WORDS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .base_addr (base_r),
    .in_chan   (in_chan),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  assign res_ready = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_r <= res;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.load_data    = out_r.load_data;
  assign out_chan.out_of_range = out_r.out_of_range;

endmodule

`default_nettype wire

[dv/mlsu_access_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// mlsu access checker
// watches the access, result and base register ports of the load/store
// unit, keeps its own image of the bank and base address, predicts every
// result word and compares it field by field in order of acceptance
// ---------------------------------------------------------------------------
module mlsu_access_checker #(
  parameter int BANK_WORDS = 1024
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_wr_en,
  input  mlsu_pkg::word_t cfg_wr_data,
  mlsu_in_if              in_mon,
  mlsu_out_if             out_mon,
  output int              mismatches,
  output int              pending
);
  import mlsu_pkg::*;

  localparam int BANK_BYTES = BANK_WORDS * 8;

  word_t bank_base;
  word_t bank_image [BANK_WORDS];
  res_t  expected_results [$];
  res_t  want;
  res_t  predicted;

  task automatic report_mismatch(input string what, input word_t got, input word_t exp_val);
    mismatches++;
    $display("[%0t] mismatch: %s got %h expected %h", $time, what, got, exp_val);
  endtask

  function automatic res_t predict_access(input logic func, input word_t addr,
                                          input count_t cnt_raw, input logic sx,
                                          input word_t data);
    res_t        r;
    word_t       rel;
    word_t       val;
    word_t       b;
    int unsigned cnt;
    r = '0;
    val = '0;
    cnt = (cnt_raw > MAX_BYTES) ? MAX_BYTES : cnt_raw;
    rel = addr - bank_base;
    if (cnt == 0) return r;
    if (rel > word_t'(BANK_BYTES - cnt)) begin
      r.out_of_range = 1'b1;
      return r;
    end
    for (int i = 0; i < cnt; i++) begin
      b = rel + i;
      if (func == FUNC_STORE) begin
        bank_image[b >> 3][b[2:0]*8 +: 8] = data[i*8 +: 8];
      end else begin
        val[i*8 +: 8] = bank_image[b >> 3][b[2:0]*8 +: 8];
      end
    end
    if (sx) begin
      case (cnt)
        1: val = {{56{val[7]}}, val[7:0]};
        2: val = {{48{val[15]}}, val[15:0]};
        4: val = {{32{val[31]}}, val[31:0]};
        default: ;
      endcase
    end
    if (func == FUNC_LOAD) r.load_data = val;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      bank_base = '0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result word with no access outstanding", out_mon.load_data, '0);
        end else begin
          want = expected_results.pop_front();
          if (out_mon.load_data !== want.load_data)
            report_mismatch("load_data", out_mon.load_data, want.load_data);
          if (out_mon.out_of_range !== want.out_of_range)
            report_mismatch("out_of_range", word_t'(out_mon.out_of_range),
                            word_t'(want.out_of_range));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        predicted = predict_access(in_mon.func, in_mon.address, in_mon.byte_count,
                                   in_mon.sign_extend, in_mon.store_data);
        expected_results = {expected_results, predicted};
      end
      if (cfg_wr_en) bank_base = cfg_wr_data;
    end
    pending <= expected_results.size();
  end

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// drives the load/store unit with directed and random loads and stores over
// several base addresses and idle patterns, tracks which bank bytes hold
// stored data so that loads only read written bytes, and gives the verdict
// from the checker's mismatch count
// ---------------------------------------------------------------------------
module tb_top;
  import mlsu_pkg::*;

  localparam int BANK_WORDS      = 1024;
  localparam int BANK_BYTES      = BANK_WORDS * 8;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int HOLD_CYCLES     = 300;
  localparam int DRAIN_CYCLES    = 10;
  localparam int TIMEOUT_NS      = 2_000_000;

  logic  clk;
  logic  rst_n;
  logic  cfg_wr_en;
  word_t cfg_wr_data;
  int    mismatches;
  int    pending;
  int    send_idle;
  int    recv_stall;
  int    hold_left;
  word_t cur_base;
  bit    written [BANK_BYTES];

  mlsu_in_if  in_chan ();
  mlsu_out_if out_chan ();

  misaligned_load_store_unit #(.DEPTH_WORDS(BANK_WORDS)) u_dut (
    .clk,
    .rst_n,
    .cfg_wr_en,
    .cfg_wr_data,
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  mlsu_access_checker #(.BANK_WORDS(BANK_WORDS)) u_checker (
    .clk,
    .rst_n,
    .cfg_wr_en,
    .cfg_wr_data,
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .mismatches,
    .pending
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_chan.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_chan.ready <= ($urandom_range(0, 99) >= recv_stall);
    end
  end

  // loads of bytes never stored are turned into stores
  task automatic issue_access(input logic func, input word_t addr, input count_t cnt,
                              input logic sx, input word_t data);
    word_t       rel;
    int unsigned eff;
    logic        kind;
    logic        all_written;
    rel = addr - cur_base;
    eff = (cnt > MAX_BYTES) ? MAX_BYTES : cnt;
    kind = func;
    if (eff != 0 && rel <= word_t'(BANK_BYTES - eff)) begin
      all_written = 1'b1;
      for (int i = 0; i < eff; i++) all_written &= written[rel + i];
      if (kind == FUNC_LOAD && !all_written) kind = FUNC_STORE;
      if (kind == FUNC_STORE) begin
        for (int i = 0; i < eff; i++) written[rel + i] = 1'b1;
      end
    end
    while ($urandom_range(0, 99) < send_idle) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid       <= 1'b1;
    in_chan.func        <= kind;
    in_chan.address     <= addr;
    in_chan.byte_count  <= cnt;
    in_chan.sign_extend <= sx;
    in_chan.store_data  <= data;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_base(input word_t value);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    cur_base = value;
  endtask

  initial begin
    #(TIMEOUT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    word_t       rel;
    word_t       base;
    count_t      cnt;
    int unsigned pick;
    rst_n               = 1'b0;
    cfg_wr_en           = 1'b0;
    cfg_wr_data         = '0;
    in_chan.valid       = 1'b0;
    in_chan.func        = FUNC_LOAD;
    in_chan.address     = '0;
    in_chan.byte_count  = '0;
    in_chan.sign_extend = 1'b0;
    in_chan.store_data  = '0;
    out_chan.ready      = 1'b0;
    send_idle           = 0;
    recv_stall          = 0;
    hold_left           = 0;
    cur_base            = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, base at zero so address equals bank offset
    write_base('0);
    issue_access(FUNC_STORE, 64'd0,  4'd8, 1'b0, 64'h8877_6655_4433_2281);
    issue_access(FUNC_STORE, 64'd8,  4'd8, 1'b0, 64'h0123_4567_89AB_CDEF);
    issue_access(FUNC_STORE, 64'd16, 4'd8, 1'b0, 64'hFEDC_BA98_7654_3210);
    issue_access(FUNC_STORE, 64'd14, 4'd4, 1'b0, 64'h0000_0000_DEAD_BEEF);
    issue_access(FUNC_LOAD,  64'd0,  4'd1, 1'b1, '0);
    issue_access(FUNC_LOAD,  64'd0,  4'd1, 1'b0, '0);
    issue_access(FUNC_LOAD,  64'd6,  4'd2, 1'b1, '0);
    issue_access(FUNC_LOAD,  64'd4,  4'd4, 1'b1, '0);
    issue_access(FUNC_LOAD,  64'd14, 4'd4, 1'b1, '0);
    issue_access(FUNC_LOAD,  64'd5,  4'd3, 1'b1, '0);
    issue_access(FUNC_LOAD,  64'd3,  4'd8, 1'b0, '0);
    issue_access(FUNC_LOAD,  64'd0,  4'd0, 1'b1, '0);
    issue_access(FUNC_STORE, 64'd0,  4'd0, 1'b0, '1);
    issue_access(FUNC_LOAD,  64'd0,  4'd15, 1'b1, '0);
    issue_access(FUNC_STORE, 64'd20, 4'd12, 1'b0, 64'hA5A5_5A5A_C3C3_3C3C);
    issue_access(FUNC_LOAD,  64'd1,  4'd6, 1'b1, '0);
    issue_access(FUNC_LOAD,  64'd2,  4'd5, 1'b1, '0);
    issue_access(FUNC_LOAD,  64'd9,  4'd7, 1'b1, '0);
    issue_access(FUNC_STORE, 64'd8184, 4'd8, 1'b0, '1);
    issue_access(FUNC_LOAD,  64'd8191, 4'd1, 1'b1, '0);
    issue_access(FUNC_LOAD,  64'd8188, 4'd8, 1'b0, '0);
    issue_access(FUNC_STORE, 64'd8191, 4'd2, 1'b0, 64'h0000_0000_0000_BEEF);
    issue_access(FUNC_LOAD,  64'd8192, 4'd1, 1'b0, '0);
    issue_access(FUNC_LOAD,  '1, 4'd8, 1'b0, '0);
    issue_access(FUNC_STORE, '1, 4'd9, 1'b0, 64'h5555_AAAA_5555_AAAA);

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       base = '1;
        1:       base = '0;
        3:       base = 64'hFFFF_FFFF_FFFF_E000;
        4:       base = 64'h8000_0000_0000_0005;
        default: base = {$urandom, $urandom};
      endcase
      write_base(base);
      case (p % 4)
        0:       begin send_idle = 0;  recv_stall = 0;  end
        1:       begin send_idle = 82; recv_stall = 0;  end
        2:       begin send_idle = 0;  recv_stall = 82; end
        default: begin send_idle = 21; recv_stall = 21; end
      endcase
      // receiver holds off while the sender keeps the input busy
      if (p == 0) hold_left = HOLD_CYCLES;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        pick = $urandom_range(0, 99);
        cnt = ($urandom_range(0, 9) == 0) ? count_t'($urandom_range(0, 15))
                                          : count_t'($urandom_range(1, 8));
        if (pick < 55) begin
          rel = $urandom_range(0, 191);
        end else if (pick < 70) begin
          rel = BANK_BYTES - $urandom_range(1, 96);
        end else if (pick < 85) begin
          rel = $urandom_range(0, BANK_BYTES - 1);
        end else if (pick < 93) begin
          rel = BANK_BYTES - $urandom_range(0, 8);
        end else begin
          rel = {$urandom, $urandom};
        end
        issue_access(logic'($urandom_range(0, 1)), cur_base + rel, cnt,
                     logic'($urandom_range(0, 1)), {$urandom, $urandom});
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
